[hdl/bmhq_pkg.sv]
// Package: entry layout, command and status codes, controller states for the heap queue.
`timescale 1ns / 1ps

package bmhq_pkg;

    localparam int KEY_W = 16;
    localparam int ID_W  = 16;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [ID_W-1:0]  t_id;

    typedef struct packed {
        t_key key;
        t_id  id;
    } t_entry;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_REMOVED  = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_UP_CHK  = 9'b000000010,
        S_UP_CMP  = 9'b000000100,
        S_TOP_RD  = 9'b000001000,
        S_LAST_RD = 9'b000010000,
        S_DN_CHK  = 9'b000100000,
        S_DN_LC   = 9'b001000000,
        S_DN_RC   = 9'b010000000,
        S_DONE    = 9'b100000000
    } t_state;

endpackage

[hdl/bmhq_req_if.sv]
// Interface: request channel carrying one command word per handshake.
`timescale 1ns / 1ps

interface bmhq_req_if;
    import bmhq_pkg::*;

    logic valid;
    logic ready;
    t_cmd cmd;
    t_id  entry_id;
    t_key prio_key;

    modport source (output valid, output cmd, output entry_id, output prio_key, input ready);
    modport sink   (input valid, input cmd, input entry_id, input prio_key, output ready);
endinterface

[hdl/bmhq_rsp_if.sv]
// Interface: response channel carrying one result word per handshake.
`timescale 1ns / 1ps

interface bmhq_rsp_if #(
    parameter int DEPTH = 64
);
    import bmhq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic             valid;
    logic             ready;
    t_status          status;
    t_id              out_id;
    t_key             out_key;
    logic [CNT_W-1:0] occupancy;

    modport source (output valid, output status, output out_id, output out_key,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input out_id, input out_key,
                    input occupancy, output ready);
endinterface

[hdl/binary_min_heap_queue.sv]
// Top level: binary min-heap priority queue over one synchronous heap memory.
// An insert climbs from the new last slot toward the root; a remove sifts the last entry
//   down from the root. One word in flight: the next word is taken the cycle after the result
//   registers, and a result that still waits holds the controller in its done state.
// Reset clears the entry count and the handshake state; the heap memory is not cleared.
`timescale 1ns / 1ps

module binary_min_heap_queue #(
    parameter int DEPTH = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bmhq_req_if.sink       i_req,
    bmhq_rsp_if.source     o_rsp
);
    import bmhq_pkg::*;

    localparam int AW = $clog2(DEPTH);      // heap address width
    localparam int CW = $clog2(DEPTH + 1);  // entry count width
    localparam int XW = AW + 2;             // child index width, holds 2*DEPTH

    // Heap storage: one write port and one registered read port.
    t_entry r_heap [DEPTH];
    t_entry r_rd_data;

    // Controller state.
    t_state        r_state,  n_state;
    logic [CW-1:0] r_count,  n_count;
    logic [AW-1:0] r_x,      n_x;       // current hole position
    t_entry        r_ent,    n_ent;     // entry being sifted
    t_entry        r_ch,     n_ch;      // smaller child seen so far
    logic [AW-1:0] r_chi,    n_chi;     // its address
    t_entry        r_top,    n_top;     // removed root
    t_status       r_status, n_status;

    // Output register, parts the response side from the controller.
    logic          r_ovalid,   n_ovalid;
    t_status       r_o_status, n_o_status;
    t_id           r_o_id,     n_o_id;
    t_key          r_o_key,    n_o_key;
    logic [CW-1:0] r_o_occ,    n_o_occ;

    // Memory port controls.
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    logic [AW-1:0] rd_addr;

    logic          in_take;
    logic [XW-1:0] lc_idx;
    logic [XW-1:0] rc_idx;
    logic [XW-1:0] cnt_ext;
    logic [AW-1:0] parent;
    logic [CW-1:0] cnt_m1;
    logic          rc_wins;

    assign in_take = i_req.valid && (r_state == S_IDLE);
    assign lc_idx  = {1'b0, r_x, 1'b1};
    assign rc_idx  = {1'b0, r_x, 1'b0} + XW'(2);
    assign cnt_ext = XW'(r_count);
    assign parent  = AW'((r_x - AW'(1)) >> 1);
    assign cnt_m1  = r_count - CW'(1);
    // Right child wins unless the left one is strictly smaller.
    assign rc_wins = !(r_ch.key < r_rd_data.key);

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_ovalid;
    assign o_rsp.status    = r_o_status;
    assign o_rsp.out_id    = r_o_id;
    assign o_rsp.out_key   = r_o_key;
    assign o_rsp.occupancy = r_o_occ;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_x        = r_x;
        n_ent      = r_ent;
        n_ch       = r_ch;
        n_chi      = r_chi;
        n_top      = r_top;
        n_status   = r_status;
        n_ovalid   = r_ovalid;
        n_o_status = r_o_status;
        n_o_id     = r_o_id;
        n_o_key    = r_o_key;
        n_o_occ    = r_o_occ;
        wr_en      = 1'b0;
        wr_addr    = r_x;
        wr_data    = r_ent;
        rd_addr    = '0;

        // Drop the pending result once the sink takes it.
        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                // Root read goes out now so a remove finds it next cycle.
                rd_addr = '0;
                if (in_take) begin
                    if (i_req.cmd == CMD_INSERT) begin
                        if (r_count == CW'(DEPTH)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_ent.key = i_req.prio_key;
                            n_ent.id  = i_req.entry_id;
                            n_x       = r_count[AW-1:0];
                            n_count   = r_count + CW'(1);
                            n_state   = S_UP_CHK;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_TOP_RD;
                        end
                    end
                end
            end
            S_UP_CHK: begin
                if (r_x == '0) begin
                    wr_en    = 1'b1;
                    n_status = ST_INSERTED;
                    n_state  = S_DONE;
                end else begin
                    rd_addr = parent;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                wr_en = 1'b1;
                if (r_ent.key < r_rd_data.key) begin
                    // Pull the parent down into the hole, climb one level.
                    wr_data = r_rd_data;
                    n_x     = parent;
                    n_state = S_UP_CHK;
                end else begin
                    n_status = ST_INSERTED;
                    n_state  = S_DONE;
                end
            end
            S_TOP_RD: begin
                n_top   = r_rd_data;
                rd_addr = cnt_m1[AW-1:0];
                n_count = cnt_m1;
                n_state = S_LAST_RD;
            end
            S_LAST_RD: begin
                n_ent   = r_rd_data;
                n_x     = '0;
                n_state = S_DN_CHK;
            end
            S_DN_CHK: begin
                if (lc_idx >= cnt_ext) begin
                    // Hole is a leaf (or heap now empty): settle the entry here.
                    wr_en    = (r_count != '0);
                    n_status = ST_REMOVED;
                    n_state  = S_DONE;
                end else begin
                    rd_addr = lc_idx[AW-1:0];
                    n_state = S_DN_LC;
                end
            end
            S_DN_LC: begin
                if (rc_idx < cnt_ext) begin
                    n_ch    = r_rd_data;
                    n_chi   = lc_idx[AW-1:0];
                    rd_addr = rc_idx[AW-1:0];
                    n_state = S_DN_RC;
                end else begin
                    wr_en = 1'b1;
                    if (r_ent.key < r_rd_data.key) begin
                        n_status = ST_REMOVED;
                        n_state  = S_DONE;
                    end else begin
                        wr_data = r_rd_data;
                        n_x     = lc_idx[AW-1:0];
                        n_state = S_DN_CHK;
                    end
                end
            end
            S_DN_RC: begin
                wr_en = 1'b1;
                if (rc_wins) begin
                    if (r_ent.key < r_rd_data.key) begin
                        n_status = ST_REMOVED;
                        n_state  = S_DONE;
                    end else begin
                        wr_data = r_rd_data;
                        n_x     = rc_idx[AW-1:0];
                        n_state = S_DN_CHK;
                    end
                end else begin
                    if (r_ent.key < r_ch.key) begin
                        n_status = ST_REMOVED;
                        n_state  = S_DONE;
                    end else begin
                        wr_data = r_ch;
                        n_x     = r_chi;
                        n_state = S_DN_CHK;
                    end
                end
            end
            S_DONE: begin
                // Hold until the output register is free, then publish the word.
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_status;
                    n_o_occ    = r_count;
                    if (r_status == ST_REMOVED) begin
                        n_o_id  = r_top.id;
                        n_o_key = r_top.key;
                    end else begin
                        n_o_id  = '0;
                        n_o_key = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_heap[wr_addr] <= wr_data;
        end
        r_rd_data <= r_heap[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_ent      <= n_ent;
        r_ch       <= n_ch;
        r_chi      <= n_chi;
        r_top      <= n_top;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_id     <= n_o_id;
        r_o_key    <= n_o_key;
        r_o_occ    <= n_o_occ;
    end

endmodule
